FILE: rtl/core/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and arithmetic helpers of the odometry block.
// ----------------------------------------------------------------------------
`default_nettype none
package odo_pkg;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_METERS_PER_COUNT = 2'd0,
    CFG_INV_WHEEL_SEP    = 2'd1,
    CFG_UPDATE_RATE      = 2'd2
  } cfg_idx_e;

  localparam logic signed [33:0] CordicGain  = 34'sd652032874;
  localparam logic [30:0]        AngleScale  = 31'd1367130551;

  typedef struct packed {
    logic signed [31:0] dl;
    logic signed [31:0] dr;
  } delta_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] sin_v;
    logic signed [32:0] cos_v;
  } trig_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] idx);
    logic signed [33:0] r;
    case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41721;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/odo_front.sv
// ----------------------------------------------------------------------------
// odo_front
// Accepts count words, forms wrapping deltas against the previous counts.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_front import odo_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // left_count, right_count
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output delta_t           q_data_o
);

  logic [31:0] last_l_q, last_r_q;

  assign s_axis_tready_o  = !q_full_i;
  assign q_push_o         = s_axis_tvalid_i && !q_full_i;
  assign q_data_o.dl      = s_axis_tdata_i[31:0] - last_l_q;
  assign q_data_o.dr      = s_axis_tdata_i[63:32] - last_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
    end else if (q_push_o) begin
      last_l_q <= s_axis_tdata_i[31:0];
      last_r_q <= s_axis_tdata_i[63:32];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/odo_fifo.sv
// ----------------------------------------------------------------------------
// odo_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_fifo import odo_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire delta_t data_i,
  input  wire logic   pop_i,
  output delta_t      data_o,
  output logic        full_o,
  output logic        empty_o
);

  delta_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation CORDIC, one step per cycle, sin and cos in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_cordic import odo_pkg::*; #(
  parameter int unsigned Steps = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] angle_i,
  output trig_t            trig_o
);

  localparam int unsigned IdxW = $clog2(Steps + 1);

  logic signed [33:0] x_q, y_q, z_q, dx, dy;
  logic [IdxW-1:0]    i_q;
  logic               busy_q, neg_q, neg_d;
  logic [31:0]        fold;

  assign neg_d = angle_i[31] ^ angle_i[30];
  assign fold  = neg_d ? {~angle_i[31], angle_i[30:0]} : angle_i;
  assign dx    = y_q >>> i_q;
  assign dy    = x_q >>> i_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= CordicGain;
      y_q   <= '0;
      z_q   <= {{2{fold[31]}}, fold};
      neg_q <= neg_d;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_at(5'(i_q));
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_at(5'(i_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == IdxW'(Steps - 1)) busy_q <= 1'b0;
    end
  end

  logic signed [33:0] s_full, c_full;
  assign s_full       = neg_q ? -y_q : y_q;
  assign c_full       = neg_q ? -x_q : x_q;
  assign trig_o.done  = !busy_q;
  assign trig_o.sin_v = s_full[32:0];
  assign trig_o.cos_v = c_full[32:0];

endmodule
`default_nettype wire

FILE: rtl/core/odo_back.sv
// ----------------------------------------------------------------------------
// odo_back
// Sequencer over one shared multiplier and two CORDIC lanes; pose update.
// ----------------------------------------------------------------------------
`default_nettype none
module odo_back import odo_pkg::*; #(
  parameter int unsigned CordicSteps = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [31:0]  mpc_i,
  input  wire logic [31:0]  inv_sep_i,
  input  wire logic [9:0]   rate_i,
  input  wire delta_t       q_data_i,
  input  wire logic         q_empty_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [159:0]      m_axis_tdata_o,
  output logic              m_axis_tuser_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ML, ST_MR, ST_DIFF, ST_MT, ST_TLO, ST_THI, ST_HEAD,
    ST_LV, ST_AV, ST_AVS, ST_WAITC, ST_MX, ST_MY, ST_ACCY, ST_OUT
  } state_e;

  state_e             state_q;
  delta_t             d_q;
  logic signed [32:0] a_s, b_s;
  logic signed [65:0] p_q;
  logic signed [47:0] ldist_q, travel_q, rdist;
  logic signed [48:0] sum49, dif49;
  logic signed [31:0] diff_q, tc_q, accx_q, accy_q, lv_q, av_q;
  logic [63:0]        turn_q;
  logic [65:0]        plo_q, tot;
  logic [31:0]        head_q, head_d;
  logic               flag_q, out_valid_q, cord_start;
  logic [159:0]       out_data_q;
  logic               out_flag_q;
  logic signed [36:0] accx_sum, accy_sum;
  logic               trav_fit, turn_fit;
  trig_t              tr_sc, tr_q;

  assign rdist    = p_q[63:16];
  assign sum49    = {ldist_q[47], ldist_q} + {rdist[47], rdist};
  assign dif49    = {rdist[47], rdist} - {ldist_q[47], ldist_q};
  assign tot      = {p_q[39:0], 26'd0} + plo_q;
  assign head_d   = head_q + tot[61:30];
  assign trav_fit = travel_q[47:32] == {16{travel_q[32]}};
  assign turn_fit = turn_q[63:56] == {8{turn_q[56]}};
  assign accx_sum = {{5{accx_q[31]}}, accx_q} + {p_q[65], p_q[65:30]};
  assign accy_sum = {{5{accy_q[31]}}, accy_q} + {p_q[65], p_q[65:30]};
  assign cord_start = state_q == ST_HEAD;
  assign q_pop_o    = state_q == ST_IDLE && !q_empty_i;

  always_comb begin
    a_s = '0;
    b_s = '0;
    case (state_q)
      ST_ML:  begin a_s = {d_q.dl[31], d_q.dl}; b_s = {1'b0, mpc_i}; end
      ST_MR:  begin a_s = {d_q.dr[31], d_q.dr}; b_s = {1'b0, mpc_i}; end
      ST_MT:  begin a_s = {diff_q[31], diff_q}; b_s = {1'b0, inv_sep_i}; end
      ST_TLO: begin a_s = {7'd0, p_q[37:12]}; b_s = {2'b0, AngleScale}; end
      ST_THI: begin a_s = {{7{turn_q[63]}}, turn_q[63:38]}; b_s = {2'b0, AngleScale}; end
      ST_LV:  begin a_s = travel_q[32:0]; b_s = {23'd0, rate_i}; end
      ST_AV:  begin a_s = turn_q[56:24]; b_s = {23'd0, rate_i}; end
      ST_MX:  begin a_s = {tc_q[31], tc_q}; b_s = tr_sc.cos_v; end
      ST_MY:  begin a_s = {tc_q[31], tc_q}; b_s = tr_sc.sin_v; end
      default: begin a_s = '0; b_s = '0; end
    endcase
  end

  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic signed [33:0] r;
    logic signed [18:0] s;
    r = {v[32], v} + 34'sd16384;
    s = r[33:15];
    if (s > 19'sd32767)       return 16'sh7fff;
    else if (s < -19'sd32768) return 16'sh8000;
    else                      return s[15:0];
  endfunction

  odo_cordic #(.Steps(CordicSteps)) u_cord_pos (
    .clk_i, .rst_ni, .start_i(cord_start), .angle_i({head_d[30:0], 1'b0}), .trig_o(tr_sc)
  );
  odo_cordic #(.Steps(CordicSteps)) u_cord_quat (
    .clk_i, .rst_ni, .start_i(cord_start), .angle_i(head_d), .trig_o(tr_q)
  );

  always_ff @(posedge clk_i) begin
    p_q <= a_s * b_s;
    case (state_q)
      ST_IDLE: d_q <= q_data_i;
      ST_MR:   ldist_q <= p_q[63:16];
      ST_DIFF: begin
        travel_q <= sum49[48:1];
        diff_q   <= clip32(66'(dif49));
      end
      ST_TLO:  turn_q <= p_q[63:0];
      ST_THI:  plo_q <= p_q;
      ST_HEAD: tc_q <= clip32(66'(travel_q));
      ST_AV: begin
        if (trav_fit)          lv_q <= clip32(p_q);
        else if (rate_i == '0) lv_q <= '0;
        else                   lv_q <= travel_q[47] ? 32'sh80000000 : 32'sh7fffffff;
      end
      ST_AVS: begin
        if (turn_fit)          av_q <= clip32(p_q);
        else if (rate_i == '0) av_q <= '0;
        else                   av_q <= turn_q[63] ? 32'sh80000000 : 32'sh7fffffff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      accx_q      <= '0;
      accy_q      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_flag_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          flag_q <= 1'b0;
          if (!q_empty_i) state_q <= ST_ML;
        end
        ST_ML:   state_q <= ST_MR;
        ST_MR:   state_q <= ST_DIFF;
        ST_DIFF: begin
          if (ovf32(66'(dif49))) flag_q <= 1'b1;
          state_q <= ST_MT;
        end
        ST_MT:   state_q <= ST_TLO;
        ST_TLO:  state_q <= ST_THI;
        ST_THI:  state_q <= ST_HEAD;
        ST_HEAD: begin
          head_q <= head_d;
          if (ovf32(66'(travel_q))) flag_q <= 1'b1;
          state_q <= ST_LV;
        end
        ST_LV:   state_q <= ST_AV;
        ST_AV: begin
          if (trav_fit ? ovf32(p_q) : rate_i != '0) flag_q <= 1'b1;
          state_q <= ST_AVS;
        end
        ST_AVS: begin
          if (turn_fit ? ovf32(p_q) : rate_i != '0) flag_q <= 1'b1;
          state_q <= ST_WAITC;
        end
        ST_WAITC: if (tr_sc.done && tr_q.done) state_q <= ST_MX;
        ST_MX:   state_q <= ST_MY;
        ST_MY: begin
          accx_q <= clip32(66'(accx_sum));
          if (ovf32(66'(accx_sum))) flag_q <= 1'b1;
          state_q <= ST_ACCY;
        end
        ST_ACCY: begin
          accy_q <= clip32(66'(accy_sum));
          if (ovf32(66'(accy_sum))) flag_q <= 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {av_q, lv_q, to_q15(tr_q.cos_v), to_q15(tr_q.sin_v),
                            accy_q, accx_q};
            out_flag_q  <= flag_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_flag_q;

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside output state");
  a_mx_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MX |-> $past(state_q) == ST_WAITC && tr_sc.done && tr_q.done)
    else $error("position step before rotation finished");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == ST_ML)
    else $error("popped word not taken");

endmodule
`default_nettype wire

FILE: rtl/core/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive dead-reckoning odometry, fixed point.
// ----------------------------------------------------------------------------
// Usage: one slave word per odometry period carries the cumulative left and
// right encoder counts. The front forms count deltas and pushes them into a
// two-entry queue; the back works one word at a time through a shared 33x33
// multiplier and two iterative CORDIC lanes, then holds the pose, quaternion,
// speeds and saturation flag in an output register on the master side.
// The time per word is set by the multiplier sequence and the CORDIC
// iterations; the back takes the next word only after the last is output.
// The slave side keeps accepting while the queue has room, so a stalled
// master side holds the result and backs up the queue, then the slave side.
// Configuration writes take effect at once and are always accepted; write
// only while idle. Reset clears counts, pose and heading and loads the
// default register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module diff_drive_odometry import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [63:0]        s_axis_tdata,   // left_count, right_count
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // pos_x, pos_y, orient_z, orient_w, lin_vel, ang_vel
  output logic [159:0]            m_axis_tdata,
  output logic                    m_axis_tuser,   // sat_flag
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  logic [31:0] mpc_q, inv_sep_q;
  logic [9:0]  rate_q;
  logic        q_push, q_pop, q_full, q_empty;
  delta_t      q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpc_q     <= 32'd21082871;
      inv_sep_q <= 32'd49344753;
      rate_q    <= 10'd20;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_METERS_PER_COUNT: mpc_q     <= cfg_data_i;
        CFG_INV_WHEEL_SEP:    inv_sep_q <= cfg_data_i;
        CFG_UPDATE_RATE:      rate_q    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  odo_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata),
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  odo_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_wdata), .pop_i(q_pop),
    .data_o(q_rdata), .full_o(q_full), .empty_o(q_empty)
  );

  odo_back #(.CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .mpc_i(mpc_q), .inv_sep_i(inv_sep_q), .rate_i(rate_q),
    .q_data_i(q_rdata), .q_empty_i(q_empty), .q_pop_o(q_pop),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata), .m_axis_tuser_o(m_axis_tuser)
  );

endmodule
`default_nettype wire

FILE: test/diff_drive_odometry_tb.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_tb
// Self-checking bench for the differential-drive odometry block. A driver
// streams cumulative encoder counts from a queue, an internal fixed-point
// model predicts pose, quaternion, speeds and saturation for each accepted
// word, and a monitor checks every result word against the oldest prediction.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module diff_drive_odometry_tb;
  import odo_pkg::*;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 400;
  localparam longint      SatLo       = -64'sd2147483648;
  localparam longint      SatHi       = 64'sd2147483647;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] ang_vel;
    logic signed [31:0] lin_vel;
    logic signed [15:0] orient_w;
    logic signed [15:0] orient_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_word_t;

  localparam longint ArcTab [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  diff_drive_odometry #(.CORDIC_STEPS(CordicSteps)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  logic [31:0] mpc_q = 32'd21082871;
  logic [31:0] inv_sep_q = 32'd49344753;
  logic [9:0]  rate_q = 10'd20;
  logic [31:0] prev_left = '0;
  logic [31:0] prev_right = '0;
  longint      pos_x_acc = 0;
  longint      pos_y_acc = 0;
  logic [31:0] heading = '0;

  logic [63:0] count_q[$];
  pose_word_t  pose_q[$];
  int unsigned errors = 0;
  int unsigned cyc = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] gen_left = '0;
  logic [31:0] gen_right = '0;

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                      inout bit f);
    if (v > hi) begin
      f = 1'b1;
      return hi;
    end
    if (v < lo) begin
      f = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void sin_cos(input logic [31:0] ang, output longint sv, output longint cv);
    logic [31:0] a;
    bit neg;
    longint x, y, z, dx, dy;
    a = ang;
    neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (neg) a = a + 32'h80000000;
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ArcTab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ArcTab[i];
      end
    end
    sv = neg ? -y : y;
    cv = neg ? -x : x;
  endfunction

  function automatic logic [15:0] half_q15(input longint v);
    bit dummy;
    dummy = 1'b0;
    return 16'(clamp_to((v + 16384) >>> 15, -32768, 32767, dummy));
  endfunction

  function automatic pose_word_t advance_pose(input logic [31:0] lc, input logic [31:0] rc);
    pose_word_t r;
    bit f;
    longint dl, dr, ld, rd, trav, diff, turn, t, tc, s, c, qs, qc;
    logic [63:0] prod;
    f = 1'b0;
    dl = longint'($signed(lc - prev_left));
    dr = longint'($signed(rc - prev_right));
    prev_left = lc;
    prev_right = rc;
    ld = (dl * longint'({32'b0, mpc_q})) >>> 16;
    rd = (dr * longint'({32'b0, mpc_q})) >>> 16;
    trav = (ld + rd) >>> 1;
    diff = clamp_to(rd - ld, SatLo, SatHi, f);
    turn = diff * longint'({32'b0, inv_sep_q});
    t = turn >>> 12;
    prod = 64'(t) * 64'd1367130551;
    heading = heading + prod[61:30];
    sin_cos({heading[30:0], 1'b0}, s, c);
    tc = clamp_to(trav, SatLo, SatHi, f);
    pos_x_acc = clamp_to(pos_x_acc + ((tc * c) >>> 30), SatLo, SatHi, f);
    pos_y_acc = clamp_to(pos_y_acc + ((tc * s) >>> 30), SatLo, SatHi, f);
    sin_cos(heading, qs, qc);
    r.pos_x = 32'(pos_x_acc);
    r.pos_y = 32'(pos_y_acc);
    r.orient_z = half_q15(qs);
    r.orient_w = half_q15(qc);
    r.lin_vel = 32'(clamp_to(trav * longint'(rate_q), SatLo, SatHi, f));
    r.ang_vel = 32'(clamp_to((turn >>> 24) * longint'(rate_q), SatLo, SatHi, f));
    r.sat = f;
    return r;
  endfunction

  function automatic bit idle_roll();
    if (cyc > 3000 && cyc < 9000) return 1'b0;
    return $urandom_range(0, 99) < 23;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("diff_drive_odometry verification failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i) begin
    logic        nv;
    logic [63:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pose_q.push_back(advance_pose(s_axis_tdata[31:0], s_axis_tdata[63:32]));
        nv = 1'b0;
      end
      if (!nv) begin
        if (count_q.size() > 0 && !idle_roll()) begin
          nv = 1'b1;
          nd = count_q.pop_front();
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // monitor
  always @(posedge clk_i) begin
    pose_word_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end else begin
          want = pose_q.pop_front();
          if (got.pos_x !== want.pos_x) begin
            errors++;
            $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
          end
          if (got.pos_y !== want.pos_y) begin
            errors++;
            $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
          end
          if (got.orient_z !== want.orient_z) begin
            errors++;
            $display("%0t: orient_z expected %h actual %h", $time, want.orient_z, got.orient_z);
          end
          if (got.orient_w !== want.orient_w) begin
            errors++;
            $display("%0t: orient_w expected %h actual %h", $time, want.orient_w, got.orient_w);
          end
          if (got.lin_vel !== want.lin_vel) begin
            errors++;
            $display("%0t: lin_vel expected %h actual %h", $time, want.lin_vel, got.lin_vel);
          end
          if (got.ang_vel !== want.ang_vel) begin
            errors++;
            $display("%0t: ang_vel expected %h actual %h", $time, want.ang_vel, got.ang_vel);
          end
          if (got.sat !== want.sat) begin
            errors++;
            $display("%0t: sat_flag expected %b actual %b", $time, want.sat, got.sat);
          end
        end
      end
    end
  end

  // receiver: random idling plus one long hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_roll();
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_METERS_PER_COUNT: mpc_q = val;
      CFG_INV_WHEEL_SEP:    inv_sep_q = val;
      CFG_UPDATE_RATE:      rate_q = val[9:0];
      default: ;
    endcase
  endtask

  task automatic push_counts(input logic [31:0] l, input logic [31:0] r);
    gen_left = l;
    gen_right = r;
    count_q.push_back({r, l});
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned mode;
    int d, spin;
    for (int unsigned k = 0; k < n; k++) begin
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
        d = int'($urandom_range(0, 4000)) - 2000;
        push_counts(gen_left + 32'(d), gen_right + 32'(d + int'($urandom_range(0, 400)) - 200));
      end else if (mode < 87) begin
        spin = int'($urandom_range(0, 2000000)) - 1000000;
        push_counts(gen_left - 32'(spin), gen_right + 32'(spin));
      end else if (mode < 95) begin
        push_counts($urandom, $urandom);
      end else begin
        push_counts(gen_left, gen_right);
      end
    end
  endtask

  task automatic wait_idle();
    while (count_q.size() > 0 || s_axis_tvalid || pose_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, counter wrap, zero delta, spins
    push_counts(32'h0, 32'h0);
    push_counts(32'h7fffffff, 32'h7fffffff);
    push_counts(32'h80000000, 32'h80000000);
    push_counts(32'hffffffff, 32'h00000000);
    push_counts(32'h00000000, 32'hffffffff);
    push_counts(32'h80000000, 32'h7fffffff);
    push_counts(32'h7fffffff, 32'h80000000);
    for (int k = 0; k < 8; k++) push_counts(gen_left - 32'd400000, gen_right + 32'd400000);
    push_counts(gen_left + 32'd1000, gen_right + 32'd1000);
    push_counts(gen_left, gen_right);
    push_counts(32'haaaaaaaa, 32'h55555555);
    push_counts(32'h55555555, 32'haaaaaaaa);
    wait_idle();
    push_random(100);
    wait_idle();

    write_reg(CFG_METERS_PER_COUNT, 32'hffffffff);
    write_reg(CFG_INV_WHEEL_SEP, 32'hffffffff);
    write_reg(CFG_UPDATE_RATE, 32'd1000);
    hold_req = 1'b1;
    push_random(90);
    wait_idle();

    write_reg(CFG_METERS_PER_COUNT, 32'd0);
    write_reg(CFG_INV_WHEEL_SEP, 32'd0);
    write_reg(CFG_UPDATE_RATE, 32'd0);
    push_random(60);
    wait_idle();

    write_reg(CFG_METERS_PER_COUNT, 32'd65536);
    write_reg(CFG_INV_WHEEL_SEP, 32'd16777216);
    write_reg(CFG_UPDATE_RATE, 32'd1);
    push_random(80);
    wait_idle();

    write_reg(cfg_idx_e'(2'd3), 32'h12345678);
    push_random(40);
    wait_idle();

    write_reg(CFG_METERS_PER_COUNT, $urandom);
    write_reg(CFG_INV_WHEEL_SEP, $urandom);
    write_reg(CFG_UPDATE_RATE, 32'($urandom_range(1, 1000)));
    push_random(120);
    wait_idle();

    if (errors == 0) begin
      $display("diff_drive_odometry verification clean");
    end else begin
      $display("diff_drive_odometry verification failed");
    end
    $finish;
  end

endmodule
